FILE: src/assert_macros.svh
// assertion helpers for the rtl core, vslc_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is active
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, held off while reset is active
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/vslc_pkg.sv
// ----------------------------------------------------------------------------
// vslc_pkg
// types, constants and step functions of the speed limit command unit
// ----------------------------------------------------------------------------
package vslc_pkg;

    // path size limit
    localparam logic [10:0] MAX_POINTS   = 11'd1024;
    localparam logic [10:0] MIN_POINTS   = 11'd3;
    // |curvature| below 0.001 1/m in Q2.20
    localparam logic [21:0] CURV_MIN_RAW = 22'd1049;

    // stop levels
    localparam logic [1:0] STOP_NONE   = 2'd0;
    localparam logic [1:0] STOP_MEDIUM = 2'd2;

    // status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // register indexes
    localparam logic [1:0] REG_SPEED_CAP  = 2'd0;
    localparam logic [1:0] REG_LAT_ACCEL  = 2'd1;
    localparam logic [1:0] REG_STOP_DECEL = 2'd2;
    localparam logic [1:0] REG_SHORT_PATH = 2'd3;

    // pipeline layout
    localparam int NUM_STAGES = 47;
    localparam int DIV_FIRST  = 1;
    localparam int DIV_LAST   = 30;
    localparam int LSQ_FIRST  = 2;
    localparam int LSQ_LAST   = 24;
    localparam int CSQ_FIRST  = 31;
    localparam int CSQ_LAST   = 45;
    localparam int FINAL_STG  = 46;

    typedef struct packed {
        logic [15:0] speed_cap;
        logic [11:0] lateral_accel_limit;
        logic [11:0] stop_decel;
        logic [15:0] short_path_threshold;
    } cfg_t;

    typedef struct packed {
        logic        rej;
        logic [1:0]  lvl;
        logic [15:0] req;
        logic [31:0] len;
        logic        small_curv;
        logic [21:0] mag;
        logic [21:0] drem;
        logic [29:0] dsh;
        logic [45:0] lx;
        logic [22:0] lroot;
        logic [24:0] lrem;
        logic [29:0] cx;
        logic [14:0] croot;
        logic [16:0] crem;
        logic        o_status;
        logic [15:0] o_cmd;
        logic [1:0]  o_lvl;
    } stage_t;

    // one restoring divide step: quotient bit shifts in at the bottom
    function automatic logic [51:0] div_step(input logic [21:0] rem,
                                             input logic [29:0] sh,
                                             input logic [21:0] mag);
        logic [22:0] t;
        logic [21:0] r;
        logic        q;
        t = {rem, sh[29]};
        if (t >= {1'b0, mag})
        begin
            r = 22'(t - {1'b0, mag});
            q = 1'b1;
        end
        else
        begin
            r = t[21:0];
            q = 1'b0;
        end
        return {r, sh[28:0], q};
    endfunction

    // one root digit of the 46 bit length product
    function automatic logic [93:0] lsq_step(input logic [45:0] x,
                                             input logic [22:0] root,
                                             input logic [24:0] rem);
        logic [26:0] r;
        logic [26:0] trial;
        logic [22:0] nroot;
        logic [24:0] nrem;
        r     = {rem, x[45:44]};
        trial = {2'b00, root, 2'b01};
        if (r >= trial)
        begin
            nrem  = 25'(r - trial);
            nroot = {root[21:0], 1'b1};
        end
        else
        begin
            nrem  = r[24:0];
            nroot = {root[21:0], 1'b0};
        end
        return {x[43:0], 2'b00, nroot, nrem};
    endfunction

    // one root digit of the 30 bit curvature quotient
    function automatic logic [61:0] csq_step(input logic [29:0] x,
                                             input logic [14:0] root,
                                             input logic [16:0] rem);
        logic [18:0] r;
        logic [18:0] trial;
        logic [14:0] nroot;
        logic [16:0] nrem;
        r     = {rem, x[29:28]};
        trial = {2'b00, root, 2'b01};
        if (r >= trial)
        begin
            nrem  = 17'(r - trial);
            nroot = {root[13:0], 1'b1};
        end
        else
        begin
            nrem  = r[16:0];
            nroot = {root[13:0], 1'b0};
        end
        return {x[27:0], 2'b00, nroot, nrem};
    endfunction

endpackage

FILE: src/vehicle_speed_limit_command_unit.sv
// ----------------------------------------------------------------------------
// vehicle_speed_limit_command_unit
// per-tick speed command from curvature and stopping distance limits
// ----------------------------------------------------------------------------
// One control tick is taken per clock while in_stall is low; throughput is
// one tick per cycle when the result side does not stall. The 47 stages are
// the entry stage, the 30-step divide of the lateral limit by |curvature|,
// the 15-step square root of the quotient and the final limit stage, one
// step per stage; the 23-step length root runs alongside. Output stall backs
// up through the stages, so empty stages keep filling while a result waits.
// Registers sit at byte addresses 0, 4, 8, 12 on the APB-style port and should
// only be written while no tick is in flight.
module vehicle_speed_limit_command_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        requested_speed,
    input  logic signed [21:0] curvature,
    input  logic [10:0]        point_count,
    input  logic [9:0]         point_index,
    input  logic [31:0]        current_mileage,
    input  logic [31:0]        end_mileage,
    input  logic [1:0]         stop_level_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [15:0]        speed_command,
    output logic [1:0]         stop_level_out,
    output logic [31:0]        remaining_length
);

    vslc_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_cap            <= 16'd2560;
            cfg_reg.lateral_accel_limit  <= 12'd448;
            cfg_reg.stop_decel           <= 12'd256;
            cfg_reg.short_path_threshold <= 16'd64;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                vslc_pkg::REG_SPEED_CAP:  cfg_reg.speed_cap            <= pwdata[15:0];
                vslc_pkg::REG_LAT_ACCEL:  cfg_reg.lateral_accel_limit  <= pwdata[11:0];
                vslc_pkg::REG_STOP_DECEL: cfg_reg.stop_decel           <= pwdata[11:0];
                vslc_pkg::REG_SHORT_PATH: cfg_reg.short_path_threshold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            vslc_pkg::REG_SPEED_CAP:  prdata = {16'd0, cfg_reg.speed_cap};
            vslc_pkg::REG_LAT_ACCEL:  prdata = {20'd0, cfg_reg.lateral_accel_limit};
            vslc_pkg::REG_STOP_DECEL: prdata = {20'd0, cfg_reg.stop_decel};
            vslc_pkg::REG_SHORT_PATH: prdata = {16'd0, cfg_reg.short_path_threshold};
            default:                  prdata = 32'd0;
        endcase
    end

    // datapath
    vslc_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .requested_speed  (requested_speed),
        .curvature        (curvature),
        .point_count      (point_count),
        .point_index      (point_index),
        .current_mileage  (current_mileage),
        .end_mileage      (end_mileage),
        .stop_level_in    (stop_level_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .speed_command    (speed_command),
        .stop_level_out   (stop_level_out),
        .remaining_length (remaining_length)
    );

endmodule

FILE: src/vslc_core.sv
// ----------------------------------------------------------------------------
// vslc_core
// pipelined divide and square root datapath of the speed limit command
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vslc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  vslc_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         requested_speed,
    input  logic signed [21:0]  curvature,
    input  logic [10:0]         point_count,
    input  logic [9:0]          point_index,
    input  logic [31:0]         current_mileage,
    input  logic [31:0]         end_mileage,
    input  logic [1:0]          stop_level_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                status,
    output logic [15:0]         speed_command,
    output logic [1:0]          stop_level_out,
    output logic [31:0]         remaining_length
);

    localparam int N = vslc_pkg::NUM_STAGES;

    logic [N-1:0]     valid_reg;
    logic [N-1:0]     ready;
    vslc_pkg::stage_t stage_reg  [N];
    vslc_pkg::stage_t stage_next [N];
    logic [21:0]      curv_u;

    // entry stage: path check, magnitude, remaining length
    assign curv_u = curvature;

    always_comb
    begin
        stage_next[0] = '0;
        stage_next[0].rej = (point_count < vslc_pkg::MIN_POINTS) ||
                            (point_count > vslc_pkg::MAX_POINTS) ||
                            ({1'b0, point_index} >= point_count);
        stage_next[0].lvl = stop_level_in;
        stage_next[0].req = requested_speed;
        stage_next[0].mag = curv_u[21] ? 22'(~curv_u + 22'd1) : curv_u;
        stage_next[0].small_curv = (stage_next[0].mag < vslc_pkg::CURV_MIN_RAW);
        stage_next[0].len = (end_mileage > current_mileage) ?
                            (end_mileage - current_mileage) : 32'd0;
        stage_next[0].drem = {12'd0, cfg.lateral_accel_limit[11:2]};
        stage_next[0].dsh  = {cfg.lateral_accel_limit[1:0], 28'd0};
    end

    // ready ripples back from the output so bubbles are squeezed out
    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            if (s == N - 1)
            begin : g_last
                assign ready[s] = !valid_reg[s] || !out_stall;
            end
            else
            begin : g_mid
                assign ready[s] = !valid_reg[s] || ready[s+1];
            end

            if (s > 0)
            begin : g_work
                // per-stage work, picked by the stage position
                always_comb
                begin
                    logic [45:0] prod;
                    logic [15:0] vcurve;
                    logic [15:0] vlen;
                    logic [15:0] cmd;
                    logic [1:0]  lvl;
                    logic [29:0] cx_in;
                    stage_next[s] = stage_reg[s-1];
                    prod   = '0;
                    vcurve = '0;
                    vlen   = '0;
                    cmd    = '0;
                    lvl    = '0;
                    cx_in  = '0;
                    if (s == vslc_pkg::DIV_FIRST)
                    begin
                        prod = 46'({cfg.stop_decel, 1'b0}) * 46'(stage_reg[s-1].len);
                        stage_next[s].lx = prod;
                    end
                    if (s >= vslc_pkg::DIV_FIRST && s <= vslc_pkg::DIV_LAST)
                    begin
                        {stage_next[s].drem, stage_next[s].dsh} =
                            vslc_pkg::div_step(stage_reg[s-1].drem, stage_reg[s-1].dsh,
                                               stage_reg[s-1].mag);
                    end
                    if (s >= vslc_pkg::LSQ_FIRST && s <= vslc_pkg::LSQ_LAST)
                    begin
                        {stage_next[s].lx, stage_next[s].lroot, stage_next[s].lrem} =
                            vslc_pkg::lsq_step(stage_reg[s-1].lx, stage_reg[s-1].lroot,
                                               stage_reg[s-1].lrem);
                    end
                    if (s >= vslc_pkg::CSQ_FIRST && s <= vslc_pkg::CSQ_LAST)
                    begin
                        cx_in = (s == vslc_pkg::CSQ_FIRST) ? stage_reg[s-1].dsh
                                                           : stage_reg[s-1].cx;
                        {stage_next[s].cx, stage_next[s].croot, stage_next[s].crem} =
                            vslc_pkg::csq_step(cx_in, stage_reg[s-1].croot,
                                               stage_reg[s-1].crem);
                    end
                    if (s == vslc_pkg::FINAL_STG)
                    begin
                        // limits, least of three, stop level override
                        if (stage_reg[s-1].small_curv)
                            vcurve = cfg.speed_cap;
                        else if ({1'b0, stage_reg[s-1].croot} < cfg.speed_cap)
                            vcurve = {1'b0, stage_reg[s-1].croot};
                        else
                            vcurve = cfg.speed_cap;
                        vlen = (stage_reg[s-1].lroot[22:16] != 7'd0) ?
                               16'hFFFF : stage_reg[s-1].lroot[15:0];
                        cmd = stage_reg[s-1].req;
                        if (vcurve < cmd)
                            cmd = vcurve;
                        if (vlen < cmd)
                            cmd = vlen;
                        lvl = stage_reg[s-1].lvl;
                        if ((stage_reg[s-1].len < {16'd0, cfg.short_path_threshold}) &&
                            (lvl < vslc_pkg::STOP_MEDIUM))
                            lvl = vslc_pkg::STOP_MEDIUM;
                        if (lvl != vslc_pkg::STOP_NONE)
                            cmd = 16'd0;
                        if (stage_reg[s-1].rej)
                        begin
                            stage_next[s].o_status = vslc_pkg::STATUS_REJECTED;
                            stage_next[s].o_cmd    = 16'd0;
                            stage_next[s].o_lvl    = stage_reg[s-1].lvl;
                            stage_next[s].len      = 32'd0;
                        end
                        else
                        begin
                            stage_next[s].o_status = vslc_pkg::STATUS_OK;
                            stage_next[s].o_cmd    = cmd;
                            stage_next[s].o_lvl    = lvl;
                        end
                    end
                end
            end

            // valid bit travels with the stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (ready[s])
                    valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s - 1];
            end

            // stage payload
            always_ff @(posedge clk)
            begin
                if (ready[s] && ((s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s - 1]))
                    stage_reg[s] <= stage_next[s];
            end
        end
    endgenerate

    // output side
    assign in_stall         = !ready[0];
    assign out_valid        = valid_reg[N-1];
    assign status           = stage_reg[N-1].o_status;
    assign speed_command    = stage_reg[N-1].o_cmd;
    assign stop_level_out   = stage_reg[N-1].o_lvl;
    assign remaining_length = stage_reg[N-1].len;

    // checks
    `ASSERT_IMPL(a_reject_zero, out_valid && (status == vslc_pkg::STATUS_REJECTED),
        (speed_command == 16'd0) && (remaining_length == 32'd0), "rejected path not zeroed")
    `ASSERT_IMPL(a_stop_zero, out_valid && (stop_level_out != vslc_pkg::STOP_NONE),
        speed_command == 16'd0, "stop level did not force zero command")
    `ASSERT_IMPL(a_short_path, out_valid && (status == vslc_pkg::STATUS_OK) &&
        (remaining_length < {16'd0, cfg.short_path_threshold}),
        stop_level_out >= vslc_pkg::STOP_MEDIUM, "short path did not raise stop level")
    `ASSERT_IMPL(a_stall_full, in_stall, valid_reg[N-1] && out_stall,
        "input stalled while pipeline can drain")

endmodule

FILE: verif/tb_vehicle_speed_limit_command_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vehicle_speed_limit_command_unit
// self-checking bench for the speed limit command unit
// ----------------------------------------------------------------------------
// Drives control ticks through the valid/stall input with bursty gaps, stalls
// the result side on its own pattern, and compares every result with a
// bit-exact predictor of the command, stop level and remaining length.
// Registers are rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_vehicle_speed_limit_command_unit;

    typedef struct packed {
        logic [15:0] req;
        logic [21:0] curv;
        logic [10:0] count;
        logic [9:0]  index;
        logic [31:0] cur;
        logic [31:0] fin;
        logic [1:0]  lvl;
    } tick_t;

    typedef struct packed {
        logic        status;
        logic [15:0] cmd;
        logic [1:0]  lvl;
        logic [31:0] len;
    } command_t;

    // settings mirror and command predictor
    class command_scoreboard;
        logic [15:0] speed_cap;
        logic [11:0] lat_accel;
        logic [11:0] decel;
        logic [15:0] short_len;
        command_t    pending[$];
        int          errors;
        int          checked;

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                vslc_pkg::REG_SPEED_CAP:  speed_cap = val[15:0];
                vslc_pkg::REG_LAT_ACCEL:  lat_accel = val[11:0];
                vslc_pkg::REG_STOP_DECEL: decel     = val[11:0];
                vslc_pkg::REG_SHORT_PATH: short_len = val[15:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] root_floor(logic [63:0] x);
            logic [63:0] r;
            r = 0;
            for (int b = 31; b >= 0; b--)
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x)
                    r = r | (64'd1 << b);
            return r;
        endfunction

        function void note_tick(tick_t t);
            command_t    e;
            logic [63:0] mag, vc, vl, len, cmd;
            logic [1:0]  lvl;
            lvl = t.lvl;
            if (t.count < vslc_pkg::MIN_POINTS || t.count > vslc_pkg::MAX_POINTS ||
                t.index >= t.count)
            begin
                e = '{vslc_pkg::STATUS_REJECTED, 16'd0, lvl, 32'd0};
            end
            else
            begin
                mag = t.curv[21] ? (64'h400000 - t.curv) : t.curv;
                if (mag < vslc_pkg::CURV_MIN_RAW)
                    vc = speed_cap;
                else
                begin
                    vc = root_floor((64'(lat_accel) << 28) / mag);
                    if (vc > speed_cap) vc = speed_cap;
                end
                len = (t.fin > t.cur) ? t.fin - t.cur : 0;
                vl = root_floor(2 * 64'(decel) * len);
                if (vl > 64'hFFFF) vl = 64'hFFFF;
                cmd = t.req;
                if (vc < cmd) cmd = vc;
                if (vl < cmd) cmd = vl;
                if (len < short_len && lvl < vslc_pkg::STOP_MEDIUM)
                    lvl = vslc_pkg::STOP_MEDIUM;
                if (lvl != vslc_pkg::STOP_NONE) cmd = 0;
                e = '{vslc_pkg::STATUS_OK, cmd[15:0], lvl, len[31:0]};
            end
            pending.push_back(e);
        endfunction

        function void check_command(command_t a);
            command_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.cmd !== e.cmd)
            begin
                $error("speed_command exp %0d got %0d", e.cmd, a.cmd); errors++;
            end
            if (a.lvl !== e.lvl)
            begin
                $error("stop_level_out exp %0d got %0d", e.lvl, a.lvl); errors++;
            end
            if (a.len !== e.len)
            begin
                $error("remaining_length exp %0d got %0d", e.len, a.len); errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [15:0] requested_speed;
    logic signed [21:0] curvature;
    logic [10:0] point_count;
    logic [9:0] point_index;
    logic [31:0] current_mileage, end_mileage;
    logic [1:0] stop_level_in;
    logic status;
    logic [15:0] speed_command;
    logic [1:0] stop_level_out;
    logic [31:0] remaining_length;

    command_scoreboard sb;
    int  sent;
    bit  hold_off;
    bit  bursty_out;

    vehicle_speed_limit_command_unit u_top (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // register write: setup then access
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, val);
    endtask

    // one tick transfer
    task automatic send_tick(tick_t t);
        in_valid <= 1;
        {requested_speed, curvature, point_count, point_index,
         current_mileage, end_mileage, stop_level_in} <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_tick(t);
        sent++;
    endtask

    task automatic idle_input(int n);
        in_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    function automatic tick_t random_tick();
        tick_t t;
        int    k;
        t.req = 16'($urandom);
        k = $urandom_range(0, 9);
        t.curv = (k < 3) ? 22'($urandom) :
                 (k < 6) ? 22'($urandom_range(0, 60000)) :
                 (k < 8) ? -22'($urandom_range(0, 60000)) : 22'($urandom_range(0, 1100));
        k = $urandom_range(0, 9);
        t.count = (k == 0) ? 11'($urandom) : 11'($urandom_range(3, 1024));
        t.index = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                              : 10'($urandom_range(0, t.count - 1));
        t.cur = $urandom;
        k = $urandom_range(0, 9);
        t.fin = (k < 2) ? 32'($urandom) : (k < 6) ? t.cur + $urandom_range(0, 200)
                                                  : t.cur + $urandom_range(0, 1 << 20);
        t.lvl = ($urandom_range(0, 3) == 0) ? 2'($urandom) : vslc_pkg::STOP_NONE;
        return t;
    endfunction

    // wait for every result, then settle the pipeline
    task automatic drain();
        int n;
        in_valid <= 0;
        n = 0;
        while (sb.pending.size() != 0 && n < 200000)
        begin
            @(posedge clk); n++;
        end
        repeat (vslc_pkg::NUM_STAGES + 5) @(posedge clk);
    endtask

    // result side stall pattern
    always @(posedge clk)
    begin
        if (!rst_n) out_stall <= 0;
        else if (hold_off) out_stall <= 1;
        else if (bursty_out) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= 0;
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_command('{status, speed_command, stop_level_out, remaining_length});

    initial
    begin
        logic [31:0] settings[4][4];
        sb = new();
        sb.set_reg(vslc_pkg::REG_SPEED_CAP, 2560); sb.set_reg(vslc_pkg::REG_LAT_ACCEL, 448);
        sb.set_reg(vslc_pkg::REG_STOP_DECEL, 256); sb.set_reg(vslc_pkg::REG_SHORT_PATH, 64);
        sent = 0; hold_off = 0; bursty_out = 0;
        rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; requested_speed = 0; curvature = 0; point_count = 0;
        point_index = 0; current_mileage = 0; end_mileage = 0; stop_level_in = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes and special cases at reset settings
        send_tick('{16'hFFFF, 22'd0, 11'd1024, 10'd1023, 32'd0, 32'hFFFFFFFF, 2'd0});
        send_tick('{16'hFFFF, 22'h200000, 11'd3, 10'd0, 32'd0, 32'd100000, 2'd0});
        send_tick('{16'hFFFF, 22'h1FFFFF, 11'd5, 10'd4, 32'd0, 32'd100000, 2'd0});
        send_tick('{16'd1000, 22'd1048, 11'd10, 10'd1, 32'd0, 32'd100000, 2'd0});
        send_tick('{16'd1000, 22'd1049, 11'd10, 10'd1, 32'd0, 32'd100000, 2'd0});
        send_tick('{16'd1000, -22'sd1049, 11'd10, 10'd1, 32'd0, 32'd100000, 2'd0});
        send_tick('{16'd500, 22'd0, 11'd2, 10'd0, 32'd0, 32'd1000, 2'd1});
        send_tick('{16'd500, 22'd0, 11'd1025, 10'd0, 32'd0, 32'd1000, 2'd3});
        send_tick('{16'd500, 22'd0, 11'd2047, 10'd0, 32'd0, 32'd1000, 2'd0});
        send_tick('{16'd500, 22'd0, 11'd10, 10'd10, 32'd0, 32'd1000, 2'd0});
        send_tick('{16'd500, 22'd0, 11'd0, 10'd0, 32'd0, 32'd1000, 2'd0});
        send_tick('{16'd500, 22'd0, 11'd10, 10'd3, 32'hFFFFFFFF, 32'd5, 2'd0});
        send_tick('{16'd500, 22'd0, 11'd10, 10'd3, 32'd100, 32'd163, 2'd1});
        send_tick('{16'd500, 22'd0, 11'd10, 10'd3, 32'd100, 32'd164, 2'd0});
        send_tick('{16'd500, 22'd0, 11'd10, 10'd3, 32'd100, 32'd5000, 2'd3});
        send_tick('{16'd0, 22'h155555, 11'd10, 10'd3, 32'd7, 32'h2AAAAAAA, 2'd2});
        drain();

        settings[0] = '{32'd0, 32'd0, 32'd0, 32'd0};
        settings[1] = '{32'hFFFF, 32'hFFF, 32'hFFF, 32'hFFFF};
        settings[2] = '{32'd3000, 32'd300, 32'd400, 32'd1};
        settings[3] = '{32'hFFFFFFFF, 32'd1, 32'd1, 32'd500};
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
                for (int r = 0; r < 4; r++)
                    write_reg(2'(r), settings[ph - 1][r]);
            bursty_out = (ph % 2 == 1);
            if (ph == 0)
            begin
                send_tick('{16'hFFFF, 22'd2000, 11'd10, 10'd1, 32'd0, 32'd99999, 2'd0});
                send_tick('{16'hFFFF, 22'd0, 11'd10, 10'd1, 32'd0, 32'd99999, 2'd0});
            end
            // long hold-off on the result side while ticks keep coming
            if (ph == 2)
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge clk);
                        hold_off = 0;
                    end
                    repeat (120) send_tick(random_tick());
                join
            for (int i = 0; i < 300; i++)
            begin
                send_tick(random_tick());
                if ($urandom_range(0, 7) == 0) idle_input($urandom_range(1, 12));
            end
            drain();
        end

        $display("ran %0d ticks, %0d results checked, 5 register settings incl. extremes",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
